/* rtl/dmx_break_framed_packet_capture_assert.svh */
// ----------------------------------------------------------------------------
// DMX break-framed capture assertion macros
// Concurrent assertion wrappers shared by the capture RTL.
// ----------------------------------------------------------------------------
`ifndef DMX_BREAK_FRAMED_PACKET_CAPTURE_ASSERT_SVH
`define DMX_BREAK_FRAMED_PACKET_CAPTURE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at every clock edge outside reset.
`define DMXCAP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DMXCAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DMXCAP_ASSERT(lbl, clk, rst, prop, msg)
`define DMXCAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/dmxcap_pkg.sv */
// ----------------------------------------------------------------------------
// DMX capture package
// Constants, operation codes and shared structs of the DMX512 capture block.
// ----------------------------------------------------------------------------
package dmxcap_pkg;

   localparam int MAX_SLOTS   = 512;
   localparam int BANK_SIZE   = MAX_SLOTS + 1;
   localparam int STORE_DEPTH = 2 * BANK_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = 10;
   localparam int INDEX_W     = 10;
   localparam int BYTE_W      = 8;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_BREAK   = 2'd1,
      OP_READ    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   // Frame store access request from the control unit
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Per-item status carried alongside the memory read
   typedef struct packed {
      logic               frame_ready;
      logic [COUNT_W-1:0] frame_length;
      logic               overflow_drop;
      logic               slot_hit;
   } item_info_type;

endpackage

/* rtl/dmxcap_ram.sv */
// ----------------------------------------------------------------------------
// DMX capture RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dmxcap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dmxcap_ctrl.sv */
// ----------------------------------------------------------------------------
// DMX capture control
// Slot counter, bank select, published length and ready flag; issues the
// frame store write for received bytes and the read for slot requests.
// ----------------------------------------------------------------------------
`include "dmx_break_framed_packet_capture_assert.svh"

module dmxcap_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  dmxcap_pkg::op_type                  operation,
   input  logic [dmxcap_pkg::BYTE_W-1:0]       data_byte,
   input  logic [dmxcap_pkg::INDEX_W-1:0]      slot_index,
   output dmxcap_pkg::mem_req_type             mem_req,
   output dmxcap_pkg::item_info_type           item_info
);

   localparam logic [dmxcap_pkg::COUNT_W-1:0] BankSizeCnt =
      dmxcap_pkg::COUNT_W'(dmxcap_pkg::BANK_SIZE);
   localparam logic [dmxcap_pkg::ADDR_W-1:0] BankBase =
      dmxcap_pkg::ADDR_W'(dmxcap_pkg::BANK_SIZE);

   logic                             bank_ff,   bank_in;
   logic [dmxcap_pkg::COUNT_W-1:0]   count_ff,  count_in;
   logic [dmxcap_pkg::COUNT_W-1:0]   length_ff, length_in;
   logic                             ready_ff,  ready_in;

   logic                             bank_full;
   logic                             slot_hit;
   logic                             drop;
   logic [dmxcap_pkg::ADDR_W-1:0]    wr_offset;
   logic [dmxcap_pkg::ADDR_W-1:0]    rd_offset;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         count_ff  <= '0;
         length_ff <= '0;
         ready_ff  <= 1'b0;
      end else begin
         bank_ff   <= bank_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         ready_ff  <= ready_in;
      end
   end

   assign bank_full = (count_ff >= BankSizeCnt);
   assign slot_hit  = (slot_index < length_ff) &&
                      (slot_index < dmxcap_pkg::INDEX_W'(dmxcap_pkg::BANK_SIZE));

   // Next state per operation
   always_comb begin
      bank_in   = bank_ff;
      count_in  = count_ff;
      length_in = length_ff;
      ready_in  = ready_ff;
      drop      = 1'b0;
      if (accept) begin
         unique case (operation)
            dmxcap_pkg::OP_BYTE: begin
               if (bank_full) begin
                  count_in = '0;
                  drop     = 1'b1;
               end else begin
                  count_in = count_ff + dmxcap_pkg::COUNT_W'(1);
               end
            end
            dmxcap_pkg::OP_BREAK: begin
               if (count_ff != '0) begin
                  length_in = count_ff;
                  ready_in  = 1'b1;
                  bank_in   = ~bank_ff;
                  count_in  = '0;
               end
            end
            dmxcap_pkg::OP_READ: begin
            end
            dmxcap_pkg::OP_RELEASE: begin
               ready_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Write into the capture bank, read from the published bank
   assign wr_offset = bank_ff ? BankBase : '0;
   assign rd_offset = bank_ff ? '0 : BankBase;

   assign mem_req.wr_en   = accept && (operation == dmxcap_pkg::OP_BYTE) && !bank_full;
   assign mem_req.wr_addr = wr_offset + dmxcap_pkg::ADDR_W'(count_ff);
   assign mem_req.wr_data = data_byte;
   assign mem_req.rd_en   = accept && (operation == dmxcap_pkg::OP_READ) && slot_hit;
   assign mem_req.rd_addr = rd_offset + dmxcap_pkg::ADDR_W'(slot_index);

   assign item_info.frame_ready   = ready_in;
   assign item_info.frame_length  = length_in;
   assign item_info.overflow_drop = drop;
   assign item_info.slot_hit      = (operation == dmxcap_pkg::OP_READ) && slot_hit;

   `DMXCAP_ASSERT(a_count_bound, clock, reset, count_ff <= BankSizeCnt, "slot count past bank size")
   `DMXCAP_ASSERT_NEXT(a_break_publish, clock, reset, accept && operation == dmxcap_pkg::OP_BREAK && count_ff != '0, count_ff == '0 && ready_ff && bank_ff != $past(bank_ff), "break did not publish frame")
   `DMXCAP_ASSERT_NEXT(a_overflow_clear, clock, reset, accept && operation == dmxcap_pkg::OP_BYTE && bank_full, count_ff == '0, "overflow did not clear slot count")
   `DMXCAP_ASSERT(a_bank_split, clock, reset, !(mem_req.wr_en && mem_req.rd_en) || mem_req.wr_addr != mem_req.rd_addr, "read and write hit the same store entry")

endmodule

/* rtl/dmx_break_framed_packet_capture.sv */
// ----------------------------------------------------------------------------
// DMX break-framed packet capture
// DMX512 receive framer with a ping-pong frame store.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser: operation; tdata: byte, slot
//   rsp      out  rsp_tvalid/tready     tdata: ready, length, value, drop
//
// One item per cycle while rsp_tready stays high; each item yields one result,
// passing through the registered read of the frame store and the output
// register. Reset is synchronous and clears the slot count, bank select,
// published length and ready flag; the store itself is not cleared, and
// req_tready stays low while reset is high. A stalled result holds the output
// register, then the read stage, then req_tready.
// ----------------------------------------------------------------------------
module dmx_break_framed_packet_capture (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [17:8] slot_index, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] frame_ready, [10:1] frame_length,
                                    // [18:11] slot_value, [19] overflow_drop, [23:20] zero
);

   logic                               accept;
   logic                               s1_advance;
   dmxcap_pkg::op_type                 operation;
   dmxcap_pkg::mem_req_type            mem_req;
   dmxcap_pkg::item_info_type          item_info;
   logic [dmxcap_pkg::BYTE_W-1:0]      rd_data;
   logic [dmxcap_pkg::BYTE_W-1:0]      slot_value;

   logic                               s1_valid_ff, s1_valid_in;
   dmxcap_pkg::item_info_type          s1_info_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [23:0]                        rsp_data_ff;

   assign operation  = dmxcap_pkg::op_type'(req_tuser);
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   dmxcap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (operation),
      .data_byte  (req_tdata[7:0]),
      .slot_index (req_tdata[17:8]),
      .mem_req    (mem_req),
      .item_info  (item_info)
   );

   dmxcap_ram #(
      .WIDTH (dmxcap_pkg::BYTE_W),
      .DEPTH (dmxcap_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // Read stage and output stage valid control
   always_comb begin
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold item status while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= item_info;
      end
   end

   // Zero the slot value unless this item read a slot within the frame
   assign slot_value = s1_info_ff.slot_hit ? rd_data : '0;

   // Load the output register
   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= {4'b0000, s1_info_ff.overflow_drop, slot_value,
                         s1_info_ff.frame_length, s1_info_ff.frame_ready};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* dv/dmx_break_framed_packet_capture_test.sv */
// ----------------------------------------------------------------------------
// DMX break-framed packet capture testbench
// Drives received bytes, breaks, slot reads and releases into the capture
// block over its request stream, takes expected responses from the directed
// table or a cycle-free model of the ping-pong frame store, and checks them
// field by field under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module dmx_break_framed_packet_capture_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 500;

   // Response fields as the block reports them
   typedef struct {
      logic                           ready;
      logic [dmxcap_pkg::COUNT_W-1:0] length;
      logic [dmxcap_pkg::BYTE_W-1:0]  value;
      logic                           drop;
   } frame_status_type;

   // One line of the directed stimulus table
   typedef struct {
      dmxcap_pkg::op_type             op;
      logic [dmxcap_pkg::BYTE_W-1:0]  data;
      logic [dmxcap_pkg::INDEX_W-1:0] slot;
      bit                             typed;
      frame_status_type               want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = dmxcap_pkg::OP_BYTE;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   // Capture model state
   logic [dmxcap_pkg::BYTE_W-1:0]  slot_mem [dmxcap_pkg::STORE_DEPTH];
   logic                           fill_bank;
   logic [dmxcap_pkg::COUNT_W-1:0] fill_count;
   logic [dmxcap_pkg::COUNT_W-1:0] pub_length;
   logic                           pub_ready;

   frame_status_type pending_status [$];
   stim_row_type     directed_rows [$];

   int gap_pct        = 0;
   int stall_pct      = 0;
   int fail_count     = 0;
   int requests_sent  = 0;
   int responses_seen = 0;
   int publish_total  = 0;
   int read_total     = 0;
   int drop_total     = 0;

   dmx_break_framed_packet_capture u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // [1:0] operation
      .req_tdata  (req_tdata),   // [7:0] data_byte, [17:8] slot_index, [23:18] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] frame_ready, [10:1] frame_length,
                                 // [18:11] slot_value, [19] overflow_drop
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one event to the capture model and return the status after it
   function automatic frame_status_type capture_event(
         dmxcap_pkg::op_type op, logic [dmxcap_pkg::BYTE_W-1:0] data,
         logic [dmxcap_pkg::INDEX_W-1:0] slot);
      frame_status_type res;
      res.value = '0;
      res.drop  = 1'b0;
      case (op)
         dmxcap_pkg::OP_BYTE: begin
            if (fill_count >= dmxcap_pkg::BANK_SIZE) begin
               fill_count = '0;
               res.drop   = 1'b1;
               drop_total++;
            end else begin
               slot_mem[int'(fill_bank) * dmxcap_pkg::BANK_SIZE + int'(fill_count)] = data;
               fill_count++;
            end
         end
         dmxcap_pkg::OP_BREAK: begin
            if (fill_count != 0) begin
               pub_length = fill_count;
               pub_ready  = 1'b1;
               fill_bank  = ~fill_bank;
               fill_count = '0;
               publish_total++;
            end
         end
         dmxcap_pkg::OP_READ: begin
            read_total++;
            if (slot < pub_length)
               res.value = slot_mem[(fill_bank ? 0 : dmxcap_pkg::BANK_SIZE) + int'(slot)];
         end
         default: begin
            pub_ready = 1'b0;
         end
      endcase
      res.ready  = pub_ready;
      res.length = pub_length;
      return res;
   endfunction

   // Present one item, hold it until accepted, then record its expected status
   task automatic push_item(dmxcap_pkg::op_type op, logic [dmxcap_pkg::BYTE_W-1:0] data,
                            logic [dmxcap_pkg::INDEX_W-1:0] slot,
                            bit typed = 1'b0, frame_status_type want = '{default: '0});
      frame_status_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, slot, data};
      do @(posedge clock); while (!req_tready);
      predicted = capture_event(op, data, slot);
      pending_status.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   task automatic set_idle_phase(int phase);
      case (phase)
         1:       begin gap_pct = 53; stall_pct = 0;  end
         2:       begin gap_pct = 0;  stall_pct = 53; end
         3:       begin gap_pct = 19; stall_pct = 19; end
         default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic add_row(dmxcap_pkg::op_type op, logic [dmxcap_pkg::BYTE_W-1:0] data,
                          logic [dmxcap_pkg::INDEX_W-1:0] slot,
                          bit typed, logic ready, logic [dmxcap_pkg::COUNT_W-1:0] length,
                          logic [dmxcap_pkg::BYTE_W-1:0] value, logic drop);
      stim_row_type row;
      row.op          = op;
      row.data        = data;
      row.slot        = slot;
      row.typed       = typed;
      row.want.ready  = ready;
      row.want.length = length;
      row.want.value  = value;
      row.want.drop   = drop;
      directed_rows.push_back(row);
   endtask

   // Fill the capture bank with a run of random bytes
   task automatic push_bytes(int count);
      for (int i = 0; i < count; i++)
         push_item(dmxcap_pkg::OP_BYTE, dmxcap_pkg::BYTE_W'($urandom_range(255)), '0);
   endtask

   // Throttle the response side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      frame_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (pending_status.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_tdata[0] !== want.ready) begin
               $error("frame_ready: expected %0d, got %0d", want.ready, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[10:1] !== want.length) begin
               $error("frame_length: expected %0d, got %0d", want.length, rsp_tdata[10:1]);
               fail_count++;
            end
            if (rsp_tdata[18:11] !== want.value) begin
               $error("slot_value: expected %0d, got %0d", want.value, rsp_tdata[18:11]);
               fail_count++;
            end
            if (rsp_tdata[19] !== want.drop) begin
               $error("overflow_drop: expected %0d, got %0d", want.drop, rsp_tdata[19]);
               fail_count++;
            end
         end
      end
   end

   // End the run when neither stream moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, pending_status.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int seq_num;
      int full_at;
      int over_at;
      int mark;
      int run_len;
      int reads;
      stim_row_type row;

      fill_bank  = 1'b0;
      fill_count = '0;
      pub_length = '0;
      pub_ready  = 1'b0;
      for (int i = 0; i < dmxcap_pkg::STORE_DEPTH; i++)
         slot_mem[i] = '0;

      // Directed table: op, byte, slot, typed, ready, length, value, drop
      // reads and idle ops before any frame is published
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd512, 1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BREAK,   8'h00, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_RELEASE, 8'h00, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      // three-slot frame, start code first
      add_row(dmxcap_pkg::OP_BYTE,    8'h00, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BYTE,    8'hff, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BYTE,    8'ha5, 10'd0,   1, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BREAK,   8'h00, 10'd0,   1, 1, 10'd3, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd0,   1, 1, 10'd3, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd1,   1, 1, 10'd3, 8'hff, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd2,   1, 1, 10'd3, 8'ha5, 0);
      // reads beyond the published length
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd3,   1, 1, 10'd3, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd511, 1, 1, 10'd3, 8'h00, 0);
      // capture into the other bank while the frame is unreleased
      add_row(dmxcap_pkg::OP_BYTE,    8'h5a, 10'd0,   1, 1, 10'd3, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BYTE,    8'h3c, 10'd0,   1, 1, 10'd3, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd1,   1, 1, 10'd3, 8'hff, 0);
      // break replaces the unreleased frame
      add_row(dmxcap_pkg::OP_BREAK,   8'h00, 10'd0,   1, 1, 10'd2, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd0,   0, 0, 10'd0, 8'h00, 0);
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd1,   1, 1, 10'd2, 8'h3c, 0);
      add_row(dmxcap_pkg::OP_RELEASE, 8'h00, 10'd0,   1, 0, 10'd2, 8'h00, 0);
      // the released bank stays readable; repeated release and empty break
      add_row(dmxcap_pkg::OP_READ,    8'h00, 10'd1,   1, 0, 10'd2, 8'h3c, 0);
      add_row(dmxcap_pkg::OP_RELEASE, 8'h00, 10'd0,   1, 0, 10'd2, 8'h00, 0);
      add_row(dmxcap_pkg::OP_BREAK,   8'h00, 10'd0,   1, 0, 10'd2, 8'h00, 0);

      // Hold reset, then release it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idle_phase(0);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         push_item(row.op, row.data, row.slot, row.typed, row.want);
      end

      // Random frames, including one full-size frame and one overflow run
      full_at = $urandom_range(2, 6);
      over_at = $urandom_range(8, 14);
      seq_num = 0;
      mark    = requests_sent;
      while ((requests_sent - mark) < RANDOM_ITEMS || seq_num <= over_at) begin
         set_idle_phase(seq_num % 4);
         if (seq_num == full_at) begin
            push_item(dmxcap_pkg::OP_BREAK, '0, '0);
            push_bytes(dmxcap_pkg::BANK_SIZE);
            push_item(dmxcap_pkg::OP_BREAK, '0, '0);
            push_item(dmxcap_pkg::OP_READ, '0,
                      dmxcap_pkg::INDEX_W'(dmxcap_pkg::MAX_SLOTS));
            push_item(dmxcap_pkg::OP_READ, '0, '0);
            push_item(dmxcap_pkg::OP_READ, '0,
                      dmxcap_pkg::INDEX_W'($urandom_range(dmxcap_pkg::MAX_SLOTS)));
         end else if (seq_num == over_at) begin
            // the byte after a full bank is dropped and the count restarts
            push_item(dmxcap_pkg::OP_BREAK, '0, '0);
            push_bytes(dmxcap_pkg::BANK_SIZE + 1 + $urandom_range(3));
            push_item(dmxcap_pkg::OP_BREAK, '0, '0);
            push_item(dmxcap_pkg::OP_READ, '0, dmxcap_pkg::INDEX_W'($urandom_range(4)));
         end else if ($urandom_range(99) < 15) begin
            // noise: any operation with any field values
            repeat ($urandom_range(1, 6))
               push_item(dmxcap_pkg::op_type'($urandom_range(3)),
                         dmxcap_pkg::BYTE_W'($urandom_range(255)),
                         dmxcap_pkg::INDEX_W'($urandom_range(dmxcap_pkg::MAX_SLOTS)));
         end else begin
            // well-formed frame with random content, sometimes empty or broken
            run_len = ($urandom_range(9) == 0) ? 0 :
                      ($urandom_range(9) == 0) ? $urandom_range(13, 40) :
                                                 $urandom_range(1, 12);
            push_bytes(run_len);
            if ($urandom_range(9) != 0)
               push_item(dmxcap_pkg::OP_BREAK, '0, '0);
            reads = $urandom_range(1, 5);
            for (int r = 0; r < reads; r++) begin
               if ($urandom_range(9) == 0)
                  push_item(dmxcap_pkg::OP_READ, '0,
                            dmxcap_pkg::INDEX_W'($urandom_range(dmxcap_pkg::MAX_SLOTS)));
               else
                  push_item(dmxcap_pkg::OP_READ, '0,
                            dmxcap_pkg::INDEX_W'($urandom_range(run_len)));
            end
            if ($urandom_range(99) < 70)
               push_item(dmxcap_pkg::OP_RELEASE, dmxcap_pkg::BYTE_W'($urandom_range(255)),
                         dmxcap_pkg::INDEX_W'($urandom_range(dmxcap_pkg::MAX_SLOTS)));
         end
         seq_num++;
      end

      // Drop valid and let the response stream drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      set_idle_phase(0);
      while (pending_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests in %0d frame runs: %0d publishes,",
               requests_sent, seq_num, publish_total);
      $display("%0d slot reads, %0d drops; checked %0d responses, %0d field mismatches",
               read_total, drop_total, responses_seen, fail_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
